@@ src/button_led_pattern_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// button_led_pattern_sequencer_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef BUTTON_LED_PATTERN_SEQUENCER_ASSERT_SVH
`define BUTTON_LED_PATTERN_SEQUENCER_ASSERT_SVH

// property checked on the rising clock edge, off while reset is low
`define BLPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blps assertion failed");

// property checked on every rising clock edge, reset included
`define BLPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("blps assertion failed");

`endif

@@ src/blps_pkg.sv @@
// ----------------------------------------------------------------------------
// blps_pkg
// types and constants of the button led pattern sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package blps_pkg;

  // field widths
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CountW = 8;
  localparam int unsigned LedW   = 2;

  // phase codes
  localparam logic [PhaseW-1:0] PhaseWait   = 4'd0;
  localparam logic [PhaseW-1:0] PhaseWakeDb = 4'd1;
  localparam logic [PhaseW-1:0] PhaseDbAlt  = 4'd2;
  localparam logic [PhaseW-1:0] PhaseAlt    = 4'd3;
  localparam logic [PhaseW-1:0] PhaseDbBst  = 4'd4;
  localparam logic [PhaseW-1:0] PhaseBurst  = 4'd5;
  localparam logic [PhaseW-1:0] PhaseDbFls  = 4'd6;
  localparam logic [PhaseW-1:0] PhaseFlash  = 4'd7;
  localparam logic [PhaseW-1:0] PhaseDbSlp  = 4'd8;
  localparam logic [PhaseW-1:0] PhaseSleep  = 4'd9;

  // led drive codes
  localparam logic [LedW-1:0] LedsOff    = 2'b00;
  localparam logic [LedW-1:0] LedsFirst  = 2'b01;
  localparam logic [LedW-1:0] LedsSecond = 2'b10;
  localparam logic [LedW-1:0] LedsBoth   = 2'b11;

  // debounce limit after reset (10 ms of 256 us strobes)
  localparam logic [CountW-1:0] DebounceReset = CountW'(10 * 1000 / 256);

  // pattern step marks
  localparam logic [CountW-1:0] StepFirst  = 8'd1;
  localparam logic [CountW-1:0] StepAltB   = 8'd51;
  localparam logic [CountW-1:0] StepAltEnd = 8'd100;
  localparam logic [CountW-1:0] StepOff1   = 8'd20;
  localparam logic [CountW-1:0] StepOn2    = 8'd40;
  localparam logic [CountW-1:0] StepOff2   = 8'd60;
  localparam logic [CountW-1:0] StepOn3    = 8'd80;
  localparam logic [CountW-1:0] StepOff3   = 8'd100;
  localparam logic [CountW-1:0] StepOn4    = 8'd120;
  localparam logic [CountW-1:0] StepOff4   = 8'd140;
  localparam logic [CountW-1:0] StepBstEnd = 8'd210;
  localparam logic [CountW-1:0] StepFlsEnd = 8'd100;

  // sequencer state
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] count;
    logic [CountW-1:0] step;
    logic [LedW-1:0]   leds;
  } state_t;

endpackage

`default_nettype wire

@@ src/blps_if.sv @@
// ----------------------------------------------------------------------------
// blps_if
// valid/ready channels carrying the input and result items
// ----------------------------------------------------------------------------
`default_nettype none

// input channel: one clock tick with button level and strobes
interface blps_in_if;
  logic valid;
  logic ready;
  logic button;
  logic timer_tick;
  logic step_tick;

  modport source (output valid, output button, output timer_tick, output step_tick,
                  input ready);
  modport sink   (input valid, input button, input timer_tick, input step_tick,
                  output ready);
  modport monitor (input valid, input ready, input button, input timer_tick,
                   input step_tick);
endinterface

// result channel: led drive and phase after the tick
interface blps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] leds;
  logic [3:0] phase;
  logic       asleep;

  modport source (output valid, output leds, output phase, output asleep,
                  input ready);
  modport sink   (input valid, input leds, input phase, input asleep,
                  output ready);
  modport monitor (input valid, input ready, input leds, input phase, input asleep);
endinterface

`default_nettype wire

@@ src/button_led_pattern_sequencer.sv @@
// ----------------------------------------------------------------------------
// button_led_pattern_sequencer
// push button steps a two-led driver through blink modes and sleep
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one item per clock tick of the application: the button
//          level (1 released) and the debounce and pattern step strobes.
//   out_if returns one item for each input item: led drive, phase code and
//          the sleep flag, as they stand after that tick.
//   cfg_we_i / cfg_data_i write the debounce limit (reset value 39); write
//          it only while no item is in flight.
// Data path: an accepted item is held in the input register, then its result
//   in the state/result register.
// Throughput: one item per cycle while out_if does not stall; the state
//   update is a single pass of next-state logic between the input and state registers.
// Reset: phase 0 (wait for press), leds both on, counters cleared, no
//   result pending. No clearing pass is needed.
// Stall: a result not taken holds the state register; the input register
//   still takes one more item, then in_if.ready drops until out_if.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module button_led_pattern_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  blps_in_if.sink                     in_if,
  blps_out_if.source                  out_if,
  input  logic                        cfg_we_i,
  input  logic [blps_pkg::CountW-1:0] cfg_data_i
);
  import blps_pkg::*;

  logic [CountW-1:0] limit_q;
  logic              in_valid_q;
  logic              button_q;
  logic              timer_tick_q;
  logic              step_tick_q;
  logic              out_valid_q;
  logic              res_ready;
  logic              in_adv;
  logic              fire;
  state_t            state_q;
  state_t            state_d;

  assign res_ready   = !out_valid_q || out_if.ready;
  assign in_adv      = !in_valid_q || res_ready;
  assign fire        = in_valid_q && res_ready;
  assign in_if.ready = in_adv;

  // debounce limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DebounceReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_if.valid) begin
      button_q     <= in_if.button;
      timer_tick_q <= in_if.timer_tick;
      step_tick_q  <= in_if.step_tick;
    end
  end

  // next state for the registered item
  blps_next u_next (
    .state_i      (state_q),
    .button_i     (button_q),
    .timer_tick_i (timer_tick_q),
    .step_tick_i  (step_tick_q),
    .limit_i      (limit_q),
    .state_o      (state_d)
  );

  // state register, doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PhaseWait, count: '0, step: '0, leds: LedsBoth};
      out_valid_q <= 1'b0;
    end else if (fire) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result outputs
  assign out_if.valid  = out_valid_q;
  assign out_if.leds   = state_q.leds;
  assign out_if.phase  = state_q.phase;
  assign out_if.asleep = (state_q.phase == PhaseSleep);

endmodule

`default_nettype wire

@@ src/blps_next.sv @@
// ----------------------------------------------------------------------------
// blps_next
// next state of the sequencer for one tick
// ----------------------------------------------------------------------------
`default_nettype none

module blps_next (
  input  blps_pkg::state_t           state_i,
  input  logic                       button_i,
  input  logic                       timer_tick_i,
  input  logic                       step_tick_i,
  input  logic [blps_pkg::CountW-1:0] limit_i,
  output blps_pkg::state_t           state_o
);
  import blps_pkg::*;

  logic [CountW-1:0] db_count;
  logic              db_done;
  logic [PhaseW-1:0] db_next;
  logic [CountW-1:0] s;
  logic [LedW-1:0]   mode_leds;

  // debounce counter: clear on press, count strobes up to the limit
  always_comb begin
    if (!button_i) begin
      db_count = '0;
    end else if (timer_tick_i && (state_i.count < limit_i)) begin
      db_count = state_i.count + CountW'(1);
    end else begin
      db_count = state_i.count;
    end
    db_done = (db_count >= limit_i);
  end

  // phase reached when a debounce finishes
  always_comb begin
    unique case (state_i.phase) inside
      PhaseWakeDb: db_next = PhaseWait;
      PhaseDbSlp:  db_next = PhaseSleep;
      default:     db_next = state_i.phase + PhaseW'(1);
    endcase
  end

  // pattern table of the three blink modes
  always_comb begin
    s         = state_i.step;
    mode_leds = state_i.leds;
    case (state_i.phase)
      PhaseAlt: begin
        if (s == StepFirst) mode_leds = LedsFirst;
        else if (s == StepAltB) mode_leds = LedsSecond;
        else if (s == StepAltEnd) s = '0;
      end
      PhaseBurst: begin
        if (s == StepFirst || s == StepOn2 || s == StepOn3 || s == StepOn4) begin
          mode_leds = LedsBoth;
        end else if (s == StepOff1 || s == StepOff2 || s == StepOff3 ||
                     s == StepOff4) begin
          mode_leds = LedsOff;
        end else if (s == StepBstEnd) begin
          s = '0;
        end
      end
      default: begin
        if (s == StepFirst) mode_leds = LedsBoth;
        else if (s == StepOff1) mode_leds = LedsOff;
        else if (s == StepFlsEnd) s = '0;
      end
    endcase
  end

  // phase sequencing
  always_comb begin
    state_o = state_i;
    unique case (state_i.phase) inside
      PhaseWakeDb, PhaseDbAlt, PhaseDbBst, PhaseDbFls, PhaseDbSlp: begin
        if (state_i.phase == PhaseWakeDb) state_o.leds = LedsBoth;
        if (state_i.phase == PhaseDbSlp)  state_o.leds = LedsOff;
        state_o.count = db_count;
        if (db_done) begin
          state_o.phase = db_next;
          state_o.count = '0;
          state_o.step  = '0;
        end
      end
      PhaseAlt, PhaseBurst, PhaseFlash: begin
        if (step_tick_i) begin
          if (!button_i) begin
            if (state_i.phase == PhaseFlash) state_o.leds = LedsOff;
            state_o.phase = state_i.phase + PhaseW'(1);
            state_o.count = '0;
          end else begin
            state_o.leds = mode_leds;
            state_o.step = s + CountW'(1);
          end
        end
      end
      PhaseSleep: begin
        if (!button_i) begin
          state_o.phase = PhaseWakeDb;
          state_o.leds  = LedsBoth;
          state_o.count = '0;
        end
      end
      default: begin
        // wait for press, also taken by unused codes
        state_o.phase = PhaseWait;
        state_o.leds  = LedsBoth;
        if (!button_i) begin
          state_o.phase = PhaseDbAlt;
          state_o.count = '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/blps_checker.sv @@
// ----------------------------------------------------------------------------
// blps_checker
// port-level checks of the button led pattern sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_led_pattern_sequencer_assert.svh"

module blps_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        ready_i,
  input  logic [blps_pkg::LedW-1:0]   leds_i,
  input  logic [blps_pkg::PhaseW-1:0] phase_i,
  input  logic                        asleep_i
);
  import blps_pkg::*;

  logic [PhaseW+LedW:0] payload;

  assign payload = {phase_i, leds_i, asleep_i};

  // a stalled result item holds its payload
  `BLPS_ASSERT(a_out_hold, clk_i, rst_ni, valid_i && !ready_i |=> valid_i && $stable(payload))

  // sleep flag follows the phase code
  `BLPS_ASSERT_ALWAYS(a_asleep_phase, clk_i, asleep_i == (phase_i == PhaseSleep))

  // leds are dark in sleep and fully on while waiting for a press
  `BLPS_ASSERT(a_sleep_dark, clk_i, rst_ni, valid_i && asleep_i |-> leds_i == LedsOff)
  `BLPS_ASSERT(a_wait_lit, clk_i, rst_ni, valid_i && phase_i == PhaseWait |-> leds_i == LedsBoth)

endmodule

bind button_led_pattern_sequencer blps_checker u_blps_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (out_if.valid),
  .ready_i  (out_if.ready),
  .leds_i   (out_if.leds),
  .phase_i  (out_if.phase),
  .asleep_i (out_if.asleep)
);

`default_nettype wire

@@ dv/button_led_pattern_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// button_led_pattern_sequencer_test
// self-checking bench for the button driven led pattern sequencer
// ----------------------------------------------------------------------------
// Every accepted tick is run through a cycle-level predictor of the phase
// machine, the debounce counter and the blink patterns. The predicted led
// drive, phase and sleep flag go into a queue. Each result item is checked
// against the oldest entry. The run walks the whole press cycle by hand, then
// covers a zero and a full-scale debounce limit. It holds the result side off
// at length while ticks keep coming, then sends press/release sequences
// with random strobes under several limits. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module button_led_pattern_sequencer_test;
  import blps_pkg::*;

  // result fields of one tick
  typedef struct packed {
    logic [LedW-1:0]   leds;
    logic [PhaseW-1:0] phase;
    logic              asleep;
  } led_view_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_data_i;

  blps_in_if  in_ch ();
  blps_out_if out_ch ();

  button_led_pattern_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // predicted sequencer state
  logic [PhaseW-1:0] seq_phase = PhaseWait;
  logic [CountW-1:0] db_count  = '0;
  logic [CountW-1:0] pat_step  = '0;
  logic [LedW-1:0]   led_drive = LedsBoth;
  logic [CountW-1:0] db_limit  = DebounceReset;

  led_view_t led_view_q[$];
  int        n_errors        = 0;
  int        hold_off_cycles = 0;
  bit        quiet_stretch   = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // release counting, moves on once the count reaches the limit
  function automatic void debounce_update(input logic btn, input logic tick,
                                          input logic [PhaseW-1:0] next_phase);
    if (!btn) begin
      db_count = '0;
    end else if (tick && db_count < db_limit) begin
      db_count = db_count + 1'b1;
    end
    if (db_count >= db_limit) begin
      seq_phase = next_phase;
      db_count  = '0;
      pat_step  = '0;
    end
  endfunction

  // one step strobe of the blink pattern of the current mode
  function automatic void advance_pattern();
    logic [CountW-1:0] pos;
    pos = pat_step;
    case (seq_phase)
      PhaseAlt: begin
        if (pos == StepFirst) led_drive = LedsFirst;
        else if (pos == StepAltB) led_drive = LedsSecond;
        else if (pos == StepAltEnd) pos = '0;
      end
      PhaseBurst: begin
        if (pos == StepFirst || pos == StepOn2 || pos == StepOn3 || pos == StepOn4)
          led_drive = LedsBoth;
        else if (pos == StepOff1 || pos == StepOff2 || pos == StepOff3 ||
                 pos == StepOff4)
          led_drive = LedsOff;
        else if (pos == StepBstEnd)
          pos = '0;
      end
      default: begin
        if (pos == StepFirst) led_drive = LedsBoth;
        else if (pos == StepOff1) led_drive = LedsOff;
        else if (pos == StepFlsEnd) pos = '0;
      end
    endcase
    pat_step = pos + 1'b1;
  endfunction

  // full update for one tick, returns what the block shows afterwards
  function automatic led_view_t advance_sequencer(input logic btn, input logic tick,
                                                  input logic stp);
    led_view_t view;
    case (seq_phase)
      PhaseWakeDb: begin
        led_drive = LedsBoth;
        debounce_update(btn, tick, PhaseWait);
      end
      PhaseDbAlt, PhaseDbBst, PhaseDbFls: begin
        debounce_update(btn, tick, seq_phase + 1'b1);
      end
      PhaseAlt, PhaseBurst, PhaseFlash: begin
        if (stp) begin
          if (!btn) begin
            if (seq_phase == PhaseFlash) led_drive = LedsOff;
            seq_phase = seq_phase + 1'b1;
            db_count  = '0;
          end else begin
            advance_pattern();
          end
        end
      end
      PhaseDbSlp: begin
        led_drive = LedsOff;
        debounce_update(btn, tick, PhaseSleep);
      end
      PhaseSleep: begin
        if (!btn) begin
          seq_phase = PhaseWakeDb;
          led_drive = LedsBoth;
          db_count  = '0;
        end
      end
      default: begin
        seq_phase = PhaseWait;
        led_drive = LedsBoth;
        if (!btn) begin
          seq_phase = PhaseDbAlt;
          db_count  = '0;
        end
      end
    endcase
    view.leds   = led_drive;
    view.phase  = seq_phase;
    view.asleep = (seq_phase == PhaseSleep);
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // channel helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // offer one tick item and predict its result once accepted
  task automatic send_tick(input logic btn, input logic tick, input logic stp);
    int gap;
    gap = quiet_stretch ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid      = 1'b1;
    in_ch.button     = btn;
    in_ch.timer_tick = tick;
    in_ch.step_tick  = stp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    led_view_q.push_back(advance_sequencer(btn, tick, stp));
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (led_view_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_debounce_limit(input logic [CountW-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(posedge clk_i);
    db_limit = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // result side: random stalls plus the long hold-off when asked
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ch.ready    = 1'b0;
        hold_off_cycles = hold_off_cycles - 1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left   = stall_left - 1;
      end else begin
        out_ch.ready = 1'b1;
        if (!quiet_stretch) stall_left = pick_gap();
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    led_view_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (led_view_q.size() == 0) begin
        $display("%0t: unexpected result leds %0d phase %0d asleep %0d", $time,
                 out_ch.leds, out_ch.phase, out_ch.asleep);
        n_errors = n_errors + 1;
      end else begin
        want = led_view_q.pop_front();
        if (out_ch.leds !== want.leds) begin
          $display("%0t: leds expected %0d actual %0d", $time, want.leds, out_ch.leds);
          n_errors = n_errors + 1;
        end
        if (out_ch.phase !== want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, want.phase,
                   out_ch.phase);
          n_errors = n_errors + 1;
        end
        if (out_ch.asleep !== want.asleep) begin
          $display("%0t: asleep expected %0d actual %0d", $time, want.asleep,
                   out_ch.asleep);
          n_errors = n_errors + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // walk through every phase with a limit of one strobe
  task automatic test_full_cycle();
    write_debounce_limit(8'd1);
    // idle with the button released, all strobe mixes
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    // press, bounce, then release with a timer strobe
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    // alternate mode: two steps, press without strobe, press on strobe
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    // burst mode
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    // short flash mode, then leave with the leds off
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    // sleep, wake, wait for release
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // debounce ends on the first item of its phase
  task automatic test_zero_limit();
    write_debounce_limit(8'd0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // full-scale limit: a release must last 255 timer strobes
  task automatic test_longest_debounce();
    write_debounce_limit(8'd255);
    repeat (2) send_tick(1'b0, chance(50), chance(50));
    repeat (258) send_tick(1'b1, 1'b1, chance(50));
    repeat (2) send_tick(1'b0, 1'b1, 1'b1);
  endtask

  // result side held off while ticks keep coming, then a full drain
  task automatic test_backpressure();
    wait_drained();
    quiet_stretch   = 1'b1;
    hold_off_cycles = 60;
    repeat (30) send_tick(chance(80), chance(70), chance(70));
    quiet_stretch = 1'b0;
    wait_drained();
  endtask

  // press/release sequences with random strobe densities, plus noise
  task automatic send_random_items(input int n);
    int sent;
    int run;
    int tick_pct;
    int step_pct;
    sent = 0;
    while (sent < n) begin
      tick_pct = $urandom_range(20, 100);
      step_pct = $urandom_range(20, 100);
      if ($urandom_range(0, 99) < 80) begin
        run = $urandom_range(1, 3);
        repeat (run) send_tick(1'b0, chance(tick_pct), chance(step_pct));
        sent = sent + run;
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                          : $urandom_range(1, 40);
        repeat (run) send_tick(1'b1, chance(tick_pct), chance(step_pct));
        sent = sent + run;
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) send_tick(chance(50), chance(50), chance(50));
        sent = sent + run;
      end
    end
  endtask

  task automatic test_random_sequences();
    write_debounce_limit(8'd1);
    send_random_items(160);
    write_debounce_limit(8'd3);
    send_random_items(160);
    write_debounce_limit(DebounceReset);
    send_random_items(180);
    write_debounce_limit(8'($urandom_range(4, 16)));
    quiet_stretch = 1'b1;
    send_random_items(120);
    quiet_stretch = 1'b0;
    send_random_items(60);
    write_debounce_limit(8'd2);
    send_random_items(160);
    write_debounce_limit(8'd1);
    send_random_items(150);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.button     = 1'b1;
    in_ch.timer_tick = 1'b0;
    in_ch.step_tick  = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_full_cycle();
    test_zero_limit();
    test_longest_debounce();
    test_backpressure();
    test_random_sequences();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (led_view_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, led_view_q.size());
      n_errors = n_errors + 1;
    end
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
